FILE: rtl/core/bhp_pkg.sv
// Package for the pixel colour-space converter: beat types of the pixel and
// result channels and the fixed hue constants. Depends on nothing else.
package bhp_pkg;

  localparam int unsigned ChW = 8;

  // Hue scaling: 30 units per sector half, 180 units per full turn.
  localparam logic [7:0] HueRange = 8'd180;

  typedef struct packed {
    logic [ChW-1:0] blue;
    logic [ChW-1:0] green;
    logic [ChW-1:0] red;
  } pix_in_t;

  typedef struct packed {
    logic [ChW-1:0] hue;
    logic [ChW-1:0] saturation;
    logic [ChW-1:0] brightness;
  } hsv_out_t;

endpackage

FILE: rtl/core/bgr_to_hsv_pixel_top.sv
// Pipelined blue/green/red to hue/saturation/value converter, 8 bits per channel.
// Uses the beat types and hue constants of bhp_pkg.
//
//   channel | ports                       | beat type
//   --------+-----------------------------+-------------------
//   pixel   | in_valid, in_stall, in_data | bhp_pkg::pix_in_t
//   result  | out_valid, out_stall, out_data | bhp_pkg::hsv_out_t
//
// One pixel is taken per cycle while in_stall is low; it passes stages 1 and 2,
// the two restoring dividers, one quotient bit per stage, and the output stage.
// Reset is synchronous and clears only the valid bits of the stages.
// A stall on the result side freezes the whole pipeline in the same cycle, so
// in_stall is raised only while a finished result waits and out_stall is high.
module bgr_to_hsv_pixel_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bhp_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bhp_pkg::hsv_out_t out_data
);

  import bhp_pkg::*;

  localparam int unsigned DivBits = 8;
  localparam int unsigned RemW    = 17;
  localparam int unsigned DenW    = 9;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [ChW-1:0] mx;
    logic [ChW-1:0] d;
    logic [ChW:0]   u;       // signed channel difference shifted by d, 0..2d
    logic [1:0]     sector;
  } s1_t;

  typedef struct packed {
    logic [RemW-1:0]    rem_h;
    logic [DenW-1:0]    den_h;
    logic [DivBits-1:0] q_h;
    logic [RemW-1:0]    rem_s;
    logic [DenW-1:0]    den_s;
    logic [DivBits-1:0] q_s;
    logic [1:0]         sector;
    logic               grey;
    logic [ChW-1:0]     mx;
  } div_t;

  logic pipe_en;

  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  // Stage 1: max, min, difference and sector of the largest channel.
  logic [ChW-1:0] mx_c, mn_c, hi_c, lo_c;
  logic [1:0]     sector_c;
  s1_t            s1_nxt, s1_r;
  logic           s1_valid_r;

  always_comb begin
    mx_c = in_data.red;
    mn_c = in_data.red;
    if (in_data.green > mx_c) mx_c = in_data.green;
    if (in_data.blue > mx_c)  mx_c = in_data.blue;
    if (in_data.green < mn_c) mn_c = in_data.green;
    if (in_data.blue < mn_c)  mn_c = in_data.blue;
    if (mx_c == in_data.red) begin
      sector_c = SEC_RED;
      hi_c     = in_data.green;
      lo_c     = in_data.blue;
    end else if (mx_c == in_data.green) begin
      sector_c = SEC_GREEN;
      hi_c     = in_data.blue;
      lo_c     = in_data.red;
    end else begin
      sector_c = SEC_BLUE;
      hi_c     = in_data.red;
      lo_c     = in_data.green;
    end
    s1_nxt.mx     = mx_c;
    s1_nxt.d      = mx_c - mn_c;
    s1_nxt.u      = {1'b0, hi_c} + {1'b0, s1_nxt.d} - {1'b0, lo_c};
    s1_nxt.sector = sector_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: dividends and divisors. The hue offset is (60u + d) / 2d, which
  // is the rounded sector fraction; saturation is (510d + mx) / 2mx.
  div_t s2_nxt, s2_r;
  logic s2_valid_r;

  always_comb begin
    s2_nxt.rem_h  = RemW'(s1_r.u) * RemW'(60) + RemW'(s1_r.d);
    s2_nxt.den_h  = {s1_r.d, 1'b0};
    s2_nxt.q_h    = '0;
    s2_nxt.rem_s  = (RemW'(s1_r.d) << 9) - (RemW'(s1_r.d) << 1) + RemW'(s1_r.mx);
    s2_nxt.den_s  = {s1_r.mx, 1'b0};
    s2_nxt.q_s    = '0;
    s2_nxt.sector = s1_r.sector;
    s2_nxt.grey   = (s1_r.d == '0);
    s2_nxt.mx     = s1_r.mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_r <= s2_nxt;
    end
  end

  // Division stages: each resolves one quotient bit of both dividers,
  // most significant first.
  div_t dv_r     [DivBits];
  logic dv_valid_r [DivBits];

  for (genvar i = 0; i < DivBits; i++) begin : g_div
    localparam int unsigned Shift = DivBits - 1 - i;

    div_t            cur, dv_nxt;
    logic            cur_valid;
    logic [RemW-1:0] sh_h, sh_s;
    logic            bit_h, bit_s;

    if (i == 0) begin : g_first
      assign cur       = s2_r;
      assign cur_valid = s2_valid_r;
    end else begin : g_rest
      assign cur       = dv_r[i-1];
      assign cur_valid = dv_valid_r[i-1];
    end

    always_comb begin
      sh_h   = RemW'(cur.den_h) << Shift;
      sh_s   = RemW'(cur.den_s) << Shift;
      bit_h  = (cur.rem_h >= sh_h);
      bit_s  = (cur.rem_s >= sh_s);
      dv_nxt = cur;
      dv_nxt.rem_h = bit_h ? cur.rem_h - sh_h : cur.rem_h;
      dv_nxt.rem_s = bit_s ? cur.rem_s - sh_s : cur.rem_s;
      dv_nxt.q_h   = {cur.q_h[DivBits-2:0], bit_h};
      dv_nxt.q_s   = {cur.q_s[DivBits-2:0], bit_s};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i] <= 1'b0;
      end else if (pipe_en) begin
        dv_valid_r[i] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv_r[i] <= dv_nxt;
      end
    end
  end

  // Output stage: add the sector base and wrap the red sector into 0..179.
  div_t           dl;
  logic [ChW-1:0] base_c, hue_sum_c;
  hsv_out_t       out_nxt, out_data_r;
  logic           out_valid_r;

  assign dl = dv_r[DivBits-1];

  always_comb begin
    case (dl.sector)
      SEC_RED:   base_c = 8'd150;
      SEC_GREEN: base_c = 8'd30;
      SEC_BLUE:  base_c = 8'd90;
      default:   base_c = 8'd0;
    endcase
    hue_sum_c = base_c + dl.q_h;
    if (hue_sum_c >= HueRange) begin
      hue_sum_c = hue_sum_c - HueRange;
    end
    out_nxt.hue        = dl.grey ? '0 : hue_sum_c;
    out_nxt.saturation = dl.grey ? '0 : dl.q_s;
    out_nxt.brightness = dl.mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= dv_valid_r[DivBits-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hue < HueRange))
    else $error("hue outside 0..179");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.brightness == '0) |->
      (out_data_r.saturation == '0 && out_data_r.hue == '0))
    else $error("black pixel with non-zero hue or saturation");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid_r[DivBits-1] && !dl.grey) |->
      (dl.rem_h < RemW'(dl.den_h) && dl.rem_s < RemW'(dl.den_s)))
    else $error("divider remainder not below divisor");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && s1_valid_r) |=> (s1_valid_r && dv_valid_r[0] == $past(dv_valid_r[0])))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

FILE: dv/tb_bgr_to_hsv_pixel_top.sv
// Self-checking bench for bgr_to_hsv_pixel_top: a directed table of pixels, then random
// pixels, with random gaps on both channels and results checked against a local model.
// Depends on bhp_pkg and on the converter's top level.
module tb_bgr_to_hsv_pixel_top;
  import bhp_pkg::*;

  localparam int unsigned HueStep   = 30;
  localparam int unsigned HueTurn   = 180;
  localparam int unsigned GreenBase = 60;
  localparam int unsigned BlueBase  = 120;
  localparam int unsigned FullScale = 255;
  localparam int RandomPixels = 1450;
  localparam int DrainCycles  = 40;
  localparam int CycleLimit   = 1000000;

  typedef struct packed {
    pix_in_t  px;
    logic     typed;
    hsv_out_t want;
  } dir_row_t;

  localparam int NumDir = 22;
  // Rows with typed set carry a hand-written answer; the rest go through the model.
  localparam dir_row_t DirRows [NumDir] = '{
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, '{8'd60,  8'd255, 8'd255}},
    '{'{8'd255, 8'd0,   8'd0},   1'b1, '{8'd120, 8'd255, 8'd255}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd128}},
    '{'{8'd1,   8'd1,   8'd1},   1'b1, '{8'd0,   8'd0,   8'd1}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd0},   1'b0, '0},
    '{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd1,   8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd1},   1'b0, '0},
    '{'{8'd1,   8'd0,   8'd0},   1'b0, '0},
    '{'{8'd0,   8'd1,   8'd0},   1'b0, '0},
    '{'{8'd200, 8'd201, 8'd200}, 1'b0, '0},
    '{'{8'd1,   8'd1,   8'd2},   1'b0, '0},
    '{'{8'd0,   8'd1,   8'd4},   1'b0, '0},
    '{'{8'd170, 8'd85,  8'd255}, 1'b0, '0},
    '{'{8'd85,  8'd170, 8'd0},   1'b0, '0},
    '{'{8'd255, 8'd255, 8'd254}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd254}, 1'b0, '0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pix_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hsv_out_t out_data;

  hsv_out_t hsv_awaited [$];
  int  mismatches  = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  calm        = 1'b0;

  bgr_to_hsv_pixel_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned round_div(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsv_out_t hsv_of_pixel(pix_in_t px);
    int unsigned b, g, r, top, bottom, span, hue, sat;
    hsv_out_t res;
    b = px.blue;
    g = px.green;
    r = px.red;
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    span = top - bottom;
    // Sector order is red, green, blue, so ties fall to the earlier channel.
    if (span == 0) begin
      hue = 0;
    end else if (top == r) begin
      hue = round_div(HueTurn * span + HueStep * g - HueStep * b, span);
      if (hue >= HueTurn) hue -= HueTurn;
    end else if (top == g) begin
      hue = round_div(GreenBase * span + HueStep * b - HueStep * r, span);
    end else begin
      hue = round_div(BlueBase * span + HueStep * r - HueStep * g, span);
    end
    sat = (top == 0) ? 0 : round_div(FullScale * span, top);
    res.hue        = 8'(hue);
    res.saturation = 8'(sat);
    res.brightness = 8'(top);
    return res;
  endfunction

  // Mostly back-to-back, some short pauses and the odd long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 88) return int'($urandom_range(1, 3));
    if (roll < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic [7:0] rail_value();
    int pick;
    pick = $urandom_range(0, 3);
    return (pick < 2) ? 8'(pick) : 8'(252 + pick);
  endfunction

  task automatic send_pixel(input pix_in_t px, input logic typed, input hsv_out_t want);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    hsv_awaited.push_back(typed ? want : hsv_of_pixel(px));
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 99) < 30) stall_left = idle_len();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin : check_results
    hsv_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (hsv_awaited.size() == 0) begin
        $display("%0t: unexpected result hue %0d sat %0d val %0d", $time,
                 out_data.hue, out_data.saturation, out_data.brightness);
        mismatches++;
      end else begin
        want = hsv_awaited.pop_front();
        if (out_data.hue !== want.hue) begin
          $display("%0t: hue expected %0d got %0d", $time, want.hue, out_data.hue);
          mismatches++;
        end
        if (out_data.saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d got %0d", $time,
                   want.saturation, out_data.saturation);
          mismatches++;
        end
        if (out_data.brightness !== want.brightness) begin
          $display("%0t: brightness expected %0d got %0d", $time,
                   want.brightness, out_data.brightness);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pix_in_t px;
    int roll, base, k;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      send_pixel(DirRows[i].px, DirRows[i].typed, DirRows[i].want);
    end

    for (int n = 0; n < RandomPixels; n++) begin
      // Now and then run a stretch with no pauses on either side.
      if (n % 120 == 0) calm = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      px.blue  = 8'($urandom_range(0, 255));
      px.green = 8'($urandom_range(0, 255));
      px.red   = 8'($urandom_range(0, 255));
      if (roll >= 55 && roll < 70) begin
        px.green = px.blue;
        px.red   = px.blue;
      end else if (roll >= 70 && roll < 85) begin
        k = $urandom_range(0, 2);
        case (k)
          0: px.green = px.blue;
          1: px.red = px.green;
          default: px.blue = px.red;
        endcase
      end else if (roll >= 85 && roll < 95) begin
        // Channels close together give small differences and sharp rounding.
        base = $urandom_range(0, 252);
        px.blue  = 8'(base + $urandom_range(0, 3));
        px.green = 8'(base + $urandom_range(0, 3));
        px.red   = 8'(base + $urandom_range(0, 3));
      end else if (roll >= 95) begin
        px.blue  = rail_value();
        px.green = rail_value();
        px.red   = rail_value();
      end
      send_pixel(px, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;
    while (hsv_awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && hsv_awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
